### rtl/core/cc_pkg.sv
// Shared constants and latency helper for the circumcircle datapath.
`timescale 1ns / 1ps

package cc_pkg;

    localparam int THR_W    = 32;
    localparam int MUL_LIMB = 32;
    localparam int MUL_LAT  = 4;

    function automatic int cc_latency(input int cw);
        return 3 * MUL_LAT + 3 * cw + 2;
    endfunction

endpackage

### rtl/core/cc_mul.sv
// Pipelined signed multiplier built from 32x32 limb products.
`timescale 1ns / 1ps

module cc_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LW   = cc_pkg::MUL_LIMB;
    localparam int NA   = (AW + LW - 1) / LW;
    localparam int NB   = (BW + LW - 1) / LW;
    localparam int PW   = AW + BW;
    localparam int RWD  = LW * (NB + 1);
    localparam int SUMW = LW * (NA + NB);

    logic [NA*LW-1:0] ua_reg, ua_next;
    logic [NB*LW-1:0] ub_reg, ub_next;
    logic [2:0]       sg_reg;
    logic [2*LW-1:0]  pp_reg [0:NA-1][0:NB-1];
    logic [RWD-1:0]   row_reg [0:NA-1];
    logic [RWD-1:0]   row_next [0:NA-1];
    logic [SUMW-1:0]  acc;
    logic [PW-1:0]    mag;
    logic [PW-1:0]    p_reg, p_next;

    always_comb
    begin
        ua_next = '0;
        ub_next = '0;
        ua_next[AW-1:0] = a[AW-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
        ub_next[BW-1:0] = b[BW-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RWD'(pp_reg[i][j]) << (LW * j));
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            acc = acc + (SUMW'(row_reg[i]) << (LW * i));
        end
        mag    = acc[PW-1:0];
        p_next = sg_reg[2] ? (~mag + 1'b1) : mag;
    end

    always_ff @(posedge clk)
    begin
        ua_reg <= ua_next;
        ub_reg <= ub_next;
        sg_reg <= {sg_reg[1:0], a[AW-1] ^ b[BW-1]};
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= ua_reg[i*LW +: LW] * ub_reg[j*LW +: LW];
            end
            row_reg[i] <= row_next[i];
        end
        p_reg <= p_next;
    end

    assign p = $signed(p_reg);

endmodule

### rtl/core/cc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module cc_div #(
    parameter int NW = 170,
    parameter int DW = 138,
    parameter int QW = 33
) (
    input  logic          clk,
    input  logic [NW-1:0] m,
    input  logic [DW-1:0] d,
    output logic [QW-1:0] q,
    output logic          ovf,
    output logic          rem_nz
);

    localparam int HW = NW - QW;
    localparam int XW = (HW > DW) ? HW : DW;

    logic [DW-1:0] r_reg   [0:QW];
    logic [QW-1:0] lo_reg  [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [DW-1:0] d_reg   [0:QW];
    logic          ovf_reg [0:QW];
    logic [XW-1:0] hi_x;
    logic [XW-1:0] d_x;

    assign hi_x = XW'(m[NW-1:QW]);
    assign d_x  = XW'(d);

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= (hi_x >= d_x);
        r_reg[0]   <= hi_x[DW-1:0];
        lo_reg[0]  <= m[QW-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= d;
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DW:0] cat;
        logic [DW:0] dif;
        logic        ge;

        assign cat = {r_reg[k-1], lo_reg[k-1][QW-k]};
        assign dif = cat - {1'b0, d_reg[k-1]};
        assign ge  = (cat >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk)
        begin
            r_reg[k]   <= ge ? dif[DW-1:0] : cat[DW-1:0];
            q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
            lo_reg[k]  <= lo_reg[k-1];
            d_reg[k]   <= d_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    assign q      = q_reg[QW];
    assign ovf    = ovf_reg[QW];
    assign rem_nz = |r_reg[QW];

endmodule

### rtl/core/circumcircle_three_points.sv
// Top level: fully pipelined circumcircle (center, radius) of three 3D points.
`timescale 1ns / 1ps
//
// Usage:
//   Input beat: drive p1..p3 and pulse start; the beat is taken at any edge with
//   start high and busy low. busy is always low: one beat per cycle is accepted.
//   Result beat: done is high for exactly one cycle with center_x/y/z, radius and
//   degenerate valid in that cycle. Results come out in input order.
//   The result passes the chain of limb multipliers, the radius divider (one
//   quotient bit per stage, 2*COORD_WIDTH-2 stages) and the square root (one root
//   bit per stage).
//   The centre divider runs in parallel and is delay matched to the radius path.
//   Throughput: one beat per cycle.
//   Configuration: cfg_we/cfg_data write degenerate_threshold; write only while
//   no beat is in flight. Reset sets it to 1 (raw) and clears all valid bits.
//   The receiver cannot stall; results are never held back.
//

module circumcircle_three_points #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [cc_pkg::THR_W-1:0]      cfg_data,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p1_z,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] p2_z,
    input  logic signed [COORD_WIDTH-1:0] p3_x,
    input  logic signed [COORD_WIDTH-1:0] p3_y,
    input  logic signed [COORD_WIDTH-1:0] p3_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] center_x,
    output logic signed [COORD_WIDTH-1:0] center_y,
    output logic signed [COORD_WIDTH-1:0] center_z,
    output logic [COORD_WIDTH-2:0]        radius,
    output logic                          degenerate
);

    localparam int CW  = COORD_WIDTH;
    localparam int ML  = cc_pkg::MUL_LAT;
    localparam int DF  = CW + 1;
    localparam int PD  = 2 * DF;
    localparam int WX  = PD + 1;
    localparam int SQ  = PD + 2;
    localparam int SW  = 2 * WX + 2;
    localparam int DVW = SW + 2;
    localparam int UW  = SQ + DF + 1;
    localparam int NNW = UW + WX + 1;
    localparam int NR  = 3 * SQ;
    localparam int QC  = CW + 1;
    localparam int RW  = CW - 1;
    localparam int QR  = 2 * RW;
    localparam int TW  = cc_pkg::THR_W + 1;
    localparam int LMW = 2 * TW + 2 * FRAC_BITS;
    localparam int XLW = (SW > LMW) ? SW : LMW;
    localparam int OW  = QC + 2;

    localparam int S_DIF = 1;
    localparam int S_W   = S_DIF + ML + 1;
    localparam int S_SP  = S_W + ML;
    localparam int S_S   = S_SP + 1;
    localparam int S_PR  = S_SP + ML;
    localparam int S_NA  = S_S + ML + 2;
    localparam int S_CQ  = S_NA + QC + 1;
    localparam int S_CF  = S_CQ + 1;
    localparam int S_RQ  = S_PR + QR + 1;
    localparam int S_RT  = S_RQ + RW;
    localparam int S_OUT = S_RT + 1;
    localparam int L_DG  = S_RT - S_S;
    localparam int L_CD  = S_RT - S_CF;

    localparam logic signed [OW-1:0] TMAX = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [OW-1:0] TMIN = {{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [CW-1:0]        CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        CMIN = {1'b1, {(CW-1){1'b0}}};

    // configuration and threshold limit
    logic [cc_pkg::THR_W-1:0] thr_reg;
    logic signed [2*TW-1:0]   thr2;
    logic [LMW-1:0]           lim_reg;
    logic signed [TW-1:0]     thr_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= cc_pkg::THR_W'(1);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    assign thr_s = $signed({1'b0, thr_reg});

    cc_mul #(.AW(TW), .BW(TW)) u_lim_mul (.clk(clk), .a(thr_s), .b(thr_s), .p(thr2));

    always_ff @(posedge clk)
    begin
        lim_reg <= LMW'($unsigned(thr2)) << (2 * FRAC_BITS);
    end

    // valid chain
    logic vld_reg [0:S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= S_OUT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start;
            for (int i = 1; i <= S_OUT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign busy = 1'b0;

    // input and edge vectors
    logic signed [CW-1:0] pin_reg [0:2][0:2];
    logic signed [DF-1:0] a_reg [0:2];
    logic signed [DF-1:0] b_reg [0:2];
    logic signed [DF-1:0] c_reg [0:2];

    always_ff @(posedge clk)
    begin
        pin_reg[0][0] <= p1_x;
        pin_reg[0][1] <= p1_y;
        pin_reg[0][2] <= p1_z;
        pin_reg[1][0] <= p2_x;
        pin_reg[1][1] <= p2_y;
        pin_reg[1][2] <= p2_z;
        pin_reg[2][0] <= p3_x;
        pin_reg[2][1] <= p3_y;
        pin_reg[2][2] <= p3_z;
        for (int i = 0; i < 3; i++)
        begin
            a_reg[i] <= DF'(pin_reg[0][i]) - DF'(pin_reg[2][i]);
            b_reg[i] <= DF'(pin_reg[1][i]) - DF'(pin_reg[2][i]);
            c_reg[i] <= DF'(pin_reg[0][i]) - DF'(pin_reg[1][i]);
        end
    end

    // cross product a x b and squared side lengths
    logic signed [DF-1:0] xa [0:5];
    logic signed [DF-1:0] xb [0:5];
    logic signed [PD-1:0] xp [0:5];
    logic signed [DF-1:0] sv [0:8];
    logic signed [PD-1:0] sp [0:8];

    for (genvar k = 0; k < 3; k++)
    begin : g_xab
        assign xa[2*k]   = a_reg[(k+1)%3];
        assign xb[2*k]   = b_reg[(k+2)%3];
        assign xa[2*k+1] = a_reg[(k+2)%3];
        assign xb[2*k+1] = b_reg[(k+1)%3];
        assign sv[k]     = a_reg[k];
        assign sv[3+k]   = b_reg[k];
        assign sv[6+k]   = c_reg[k];
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_xmul
        cc_mul #(.AW(DF), .BW(DF)) u_mul (.clk(clk), .a(xa[g]), .b(xb[g]), .p(xp[g]));
    end

    for (genvar g = 0; g < 9; g++)
    begin : g_smul
        cc_mul #(.AW(DF), .BW(DF)) u_mul (.clk(clk), .a(sv[g]), .b(sv[g]), .p(sp[g]));
    end

    logic signed [WX-1:0] w_reg [0:2];
    logic signed [SQ-1:0] asq_reg, bsq_reg, csq_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            w_reg[i] <= WX'(xp[2*i]) - WX'(xp[2*i+1]);
        end
        asq_reg <= SQ'(sp[0]) + SQ'(sp[1]) + SQ'(sp[2]);
        bsq_reg <= SQ'(sp[3]) + SQ'(sp[4]) + SQ'(sp[5]);
        csq_reg <= SQ'(sp[6]) + SQ'(sp[7]) + SQ'(sp[8]);
    end

    // alignment of a, b to the weight stage; delay lines for w and |c|^2
    logic signed [DF-1:0] adl [0:ML][0:2];
    logic signed [DF-1:0] bdl [0:ML][0:2];
    logic signed [WX-1:0] wdl [0:ML][0:2];
    logic signed [SQ-1:0] cdl [0:ML-1];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            adl[0][i] <= a_reg[i];
            bdl[0][i] <= b_reg[i];
            wdl[0][i] <= w_reg[i];
            for (int s = 1; s <= ML; s++)
            begin
                adl[s][i] <= adl[s-1][i];
                bdl[s][i] <= bdl[s-1][i];
                wdl[s][i] <= wdl[s-1][i];
            end
        end
        cdl[0] <= csq_reg;
        for (int s = 1; s < ML; s++)
        begin
            cdl[s] <= cdl[s-1];
        end
    end

    // |w|^2, u = |a|^2 b - |b|^2 a, |a|^2 |b|^2 and its product with |c|^2
    logic signed [2*WX-1:0]  ww [0:2];
    logic signed [SQ+DF-1:0] ub [0:2];
    logic signed [SQ+DF-1:0] va [0:2];
    logic signed [2*SQ-1:0]  pab;
    logic signed [NR-1:0]    prod;

    for (genvar g = 0; g < 3; g++)
    begin : g_wmul
        cc_mul #(.AW(WX), .BW(WX)) u_ww (.clk(clk), .a(w_reg[g]), .b(w_reg[g]), .p(ww[g]));
        cc_mul #(.AW(SQ), .BW(DF)) u_ub (.clk(clk), .a(asq_reg), .b(bdl[ML][g]), .p(ub[g]));
        cc_mul #(.AW(SQ), .BW(DF)) u_va (.clk(clk), .a(bsq_reg), .b(adl[ML][g]), .p(va[g]));
    end

    cc_mul #(.AW(SQ), .BW(SQ)) u_pab (.clk(clk), .a(asq_reg), .b(bsq_reg), .p(pab));
    cc_mul #(.AW(2*SQ), .BW(SQ)) u_prod (.clk(clk), .a(pab), .b(cdl[ML-1]), .p(prod));

    logic signed [SW-1:0] s_reg;
    logic signed [UW-1:0] u_reg [0:2];
    logic                 dg;

    always_ff @(posedge clk)
    begin
        s_reg <= SW'(ww[0]) + SW'(ww[1]) + SW'(ww[2]);
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i] <= UW'(ub[i]) - UW'(va[i]);
        end
    end

    assign dg = (s_reg == '0) || (XLW'(s_reg[SW-2:0]) < XLW'(lim_reg));

    logic signed [SW-1:0] sdl [0:ML+1];
    logic                 dgdl [0:L_DG-1];

    always_ff @(posedge clk)
    begin
        sdl[0] <= s_reg;
        for (int s = 1; s <= ML + 1; s++)
        begin
            sdl[s] <= sdl[s-1];
        end
        dgdl[0] <= dg;
        for (int s = 1; s < L_DG; s++)
        begin
            dgdl[s] <= dgdl[s-1];
        end
    end

    // centre numerator n = u x w
    logic signed [UW-1:0]    nua [0:5];
    logic signed [WX-1:0]    nwb [0:5];
    logic signed [UW+WX-1:0] np  [0:5];

    for (genvar k = 0; k < 3; k++)
    begin : g_nab
        assign nua[2*k]   = u_reg[(k+1)%3];
        assign nwb[2*k]   = wdl[ML][(k+2)%3];
        assign nua[2*k+1] = u_reg[(k+2)%3];
        assign nwb[2*k+1] = wdl[ML][(k+1)%3];
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_nmul
        cc_mul #(.AW(UW), .BW(WX)) u_mul (.clk(clk), .a(nua[g]), .b(nwb[g]), .p(np[g]));
    end

    logic signed [NNW-1:0] n_reg [0:2];
    logic [NNW-1:0]        nabs_reg [0:2];
    logic                  nneg_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i]    <= NNW'(np[2*i]) - NNW'(np[2*i+1]);
            nneg_reg[i] <= n_reg[i][NNW-1];
            nabs_reg[i] <= n_reg[i][NNW-1] ? (~$unsigned(n_reg[i]) + 1'b1)
                                           : $unsigned(n_reg[i]);
        end
    end

    // centre division by 2|w|^2
    logic [DVW-1:0] cdiv_d;
    logic [QC-1:0]  cq   [0:2];
    logic           covf [0:2];
    logic           crnz [0:2];

    assign cdiv_d = DVW'($unsigned(sdl[S_NA-S_S-1])) << 1;

    for (genvar g = 0; g < 3; g++)
    begin : g_cdiv
        cc_div #(.NW(NNW), .DW(DVW), .QW(QC)) u_div (
            .clk    (clk),
            .m      (nabs_reg[g]),
            .d      (cdiv_d),
            .q      (cq[g]),
            .ovf    (covf[g]),
            .rem_nz (crnz[g])
        );
    end

    logic signed [CW-1:0] p3dl [0:S_CQ-1][0:2];
    logic                 ngdl [0:QC][0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p3dl[0][i] <= pin_reg[2][i];
            for (int s = 1; s < S_CQ; s++)
            begin
                p3dl[s][i] <= p3dl[s-1][i];
            end
            ngdl[0][i] <= nneg_reg[i];
            for (int s = 1; s <= QC; s++)
            begin
                ngdl[s][i] <= ngdl[s-1][i];
            end
        end
    end

    // floor offset, add P3, saturate
    logic [CW-1:0] cf_next [0:2];
    logic [CW-1:0] cf_reg  [0:2];

    always_comb
    begin
        logic signed [OW-1:0] qs;
        logic signed [OW-1:0] off;
        logic signed [OW-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            qs  = $signed({2'b00, cq[i]});
            off = ngdl[QC][i] ? (-qs - $signed(OW'(crnz[i]))) : qs;
            t   = off + OW'(p3dl[S_CQ-1][i]);
            if (covf[i])
            begin
                cf_next[i] = ngdl[QC][i] ? CMIN : CMAX;
            end
            else if (t > TMAX)
            begin
                cf_next[i] = CMAX;
            end
            else if (t < TMIN)
            begin
                cf_next[i] = CMIN;
            end
            else
            begin
                cf_next[i] = t[CW-1:0];
            end
        end
    end

    logic [CW-1:0] cfdl [0:L_CD-1][0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cf_reg[i]  <= cf_next[i];
            cfdl[0][i] <= cf_reg[i];
            for (int s = 1; s < L_CD; s++)
            begin
                cfdl[s][i] <= cfdl[s-1][i];
            end
        end
    end

    // radius: floor(prod / 4|w|^2), then integer square root
    logic [DVW-1:0] rdiv_d;
    logic [QR-1:0]  rq;
    logic           rovf;

    assign rdiv_d = DVW'($unsigned(sdl[S_PR-S_S-1])) << 2;

    cc_div #(.NW(NR), .DW(DVW), .QW(QR)) u_rdiv (
        .clk    (clk),
        .m      ($unsigned(prod)),
        .d      (rdiv_d),
        .q      (rq),
        .ovf    (rovf),
        .rem_nz ()
    );

    logic [RW-1:0] rt_reg  [0:RW-1];
    logic [RW+1:0] rm_reg  [0:RW-1];
    logic [QR-1:0] qv_reg  [0:RW-1];
    logic          sov_reg [0:RW-1];

    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        logic [RW-1:0] rt_p;
        logic [RW+1:0] rm_p;
        logic [QR-1:0] qv_p;
        logic          sov_p;
        logic [RW+3:0] cat;
        logic [RW+3:0] trial;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rt_p  = '0;
            assign rm_p  = '0;
            assign qv_p  = rq;
            assign sov_p = rovf;
        end
        else
        begin : g_next
            assign rt_p  = rt_reg[j-1];
            assign rm_p  = rm_reg[j-1];
            assign qv_p  = qv_reg[j-1];
            assign sov_p = sov_reg[j-1];
        end

        assign cat   = {rm_p, qv_p[QR-1-2*j -: 2]};
        assign trial = {2'b00, rt_p, 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge clk)
        begin
            rm_reg[j]  <= ge ? (RW+2)'(cat - trial) : (RW+2)'(cat);
            rt_reg[j]  <= {rt_p[RW-2:0], ge};
            qv_reg[j]  <= qv_p;
            sov_reg[j] <= sov_p;
        end
    end

    // output register
    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [RW-1:0] rad_reg;
    logic          dg_reg;

    always_ff @(posedge clk)
    begin
        dg_reg <= dgdl[L_DG-1];
        if (dgdl[L_DG-1])
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= '0;
        end
        else
        begin
            cx_reg  <= cfdl[L_CD-1][0];
            cy_reg  <= cfdl[L_CD-1][1];
            cz_reg  <= cfdl[L_CD-1][2];
            rad_reg <= sov_reg[RW-1] ? {RW{1'b1}} : rt_reg[RW-1];
        end
    end

    assign done       = vld_reg[S_OUT];
    assign center_x   = $signed(cx_reg);
    assign center_y   = $signed(cy_reg);
    assign center_z   = $signed(cz_reg);
    assign radius     = rad_reg;
    assign degenerate = dg_reg;

endmodule

### rtl/core/cc_chk.sv
// Port-level checker for the circumcircle block, bound to the top level.
`timescale 1ns / 1ps

module cc_chk #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] p1_x,
    input logic signed [COORD_WIDTH-1:0] p1_y,
    input logic signed [COORD_WIDTH-1:0] p1_z,
    input logic signed [COORD_WIDTH-1:0] p2_x,
    input logic signed [COORD_WIDTH-1:0] p2_y,
    input logic signed [COORD_WIDTH-1:0] p2_z,
    input logic                          done,
    input logic signed [COORD_WIDTH-1:0] center_x,
    input logic signed [COORD_WIDTH-1:0] center_y,
    input logic signed [COORD_WIDTH-1:0] center_z,
    input logic [COORD_WIDTH-2:0]        radius,
    input logic                          degenerate
);

    localparam int LAT = cc_pkg::cc_latency(COORD_WIDTH);

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat produced no result");

    a_beat_in: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching input beat");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |->
            (center_x == '0 && center_y == '0 && center_z == '0 && radius == '0))
        else $error("degenerate result with nonzero fields");

    a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(p1_x == p2_x && p1_y == p2_y && p1_z == p2_z, LAT))
            |-> degenerate)
        else $error("coincident points not flagged degenerate");

endmodule

bind circumcircle_three_points cc_chk #(.COORD_WIDTH(COORD_WIDTH)) u_cc_chk (.*);
